// ===== rtl/tlsx_pkg.sv =====
// Shared types and constants for the TLS extension list walker.
// No dependencies; used by tlsx_walker and tls_extension_list_walker.
`default_nettype none

package tlsx_pkg;

   localparam int unsigned LIST_LEN_BYTES = 2;
   localparam int unsigned HEADER_BYTES   = 4;

   localparam logic [15:0] ALPN_ID_RESET = 16'd16;

   typedef enum logic [1:0] {
      STATUS_PENDING = 2'd0,
      STATUS_SUCCESS = 2'd1,
      STATUS_LEN_ERR = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] byte_out;
      logic       alpn_data;
      logic       alpn_first;
      logic       done_res;
      status_type status;
      logic       handshake_advance;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/tlsx_walker.sv =====
// Parser state and next-state logic for the extension list walk.
// Depends on tlsx_pkg. Consumes one byte per step and forms its result.
`default_nettype none

module tlsx_walker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire logic [7:0]         data_byte,
   input  wire logic               last_byte,
   input  wire logic [15:0]        alpn_ext_id,
   output tlsx_pkg::result_type    result
);

   logic [16:0] byte_position_ff, byte_position_in;
   logic [15:0] list_len_ff, list_len_in;
   logic [31:0] header_shift_ff, header_shift_in;
   logic [2:0]  header_count_ff, header_count_in;
   logic [15:0] body_remaining_ff, body_remaining_in;
   logic        in_alpn_body_ff, in_alpn_body_in;
   logic        error_seen_ff, error_seen_in;

   logic [16:0] list_end;
   logic [17:0] ext_end;
   logic [31:0] shifted;
   logic        mark, first;
   logic        short_list;

   assign list_end = {1'b0, list_len_ff} + 17'(tlsx_pkg::LIST_LEN_BYTES);
   assign shifted  = {header_shift_ff[23:0], data_byte};
   assign ext_end  = {1'b0, byte_position_ff} + 18'd1 + {2'b00, shifted[15:0]};

   always_comb begin
      list_len_in       = list_len_ff;
      header_shift_in   = header_shift_ff;
      header_count_in   = header_count_ff;
      body_remaining_in = body_remaining_ff;
      in_alpn_body_in   = in_alpn_body_ff;
      error_seen_in     = error_seen_ff;
      mark              = 1'b0;
      first             = 1'b0;

      if (byte_position_ff == 17'd0) begin
         list_len_in = {data_byte, 8'h00};
      end else if (byte_position_ff == 17'd1) begin
         list_len_in = {list_len_ff[15:8], data_byte};
      end else if (!error_seen_ff && (byte_position_ff < list_end)) begin
         if (body_remaining_ff != 16'd0) begin
            mark              = in_alpn_body_ff;
            first             = in_alpn_body_ff &&
                                (body_remaining_ff == header_shift_ff[15:0]);
            body_remaining_in = body_remaining_ff - 16'd1;
         end else begin
            header_shift_in = shifted;
            header_count_in = header_count_ff + 3'd1;
            if (header_count_ff == 3'(tlsx_pkg::HEADER_BYTES - 1)) begin
               header_count_in = 3'd0;
               // body would run past the list end
               if (ext_end > {1'b0, list_end}) begin
                  error_seen_in     = 1'b1;
                  body_remaining_in = 16'd0;
                  in_alpn_body_in   = 1'b0;
               end else begin
                  body_remaining_in = shifted[15:0];
                  in_alpn_body_in   = (shifted[31:16] == alpn_ext_id);
               end
            end
         end
      end

      // list claims more bytes than the message holds
      short_list = (byte_position_ff != 17'd0) &&
                   (({2'b00, list_len_in} + 18'(tlsx_pkg::LIST_LEN_BYTES)) >
                    ({1'b0, byte_position_ff} + 18'd1));
      if (last_byte && short_list) begin
         error_seen_in = 1'b1;
      end

      if (last_byte) begin
         byte_position_in = 17'd0;
      end else if (byte_position_ff != '1) begin
         byte_position_in = byte_position_ff + 17'd1;
      end else begin
         byte_position_in = byte_position_ff;
      end
   end

   always_comb begin
      result.byte_out          = data_byte;
      result.alpn_data         = mark;
      result.alpn_first        = first;
      result.done_res          = last_byte;
      result.status            = tlsx_pkg::STATUS_PENDING;
      result.handshake_advance = 1'b0;
      if (last_byte) begin
         result.status            = error_seen_in ? tlsx_pkg::STATUS_LEN_ERR
                                                  : tlsx_pkg::STATUS_SUCCESS;
         result.handshake_advance = !error_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff  <= '0;
         list_len_ff       <= '0;
         header_shift_ff   <= '0;
         header_count_ff   <= '0;
         body_remaining_ff <= '0;
         in_alpn_body_ff   <= 1'b0;
         error_seen_ff     <= 1'b0;
      end else if (step) begin
         byte_position_ff <= byte_position_in;
         if (last_byte) begin
            // return to reset for the next message
            list_len_ff       <= '0;
            header_shift_ff   <= '0;
            header_count_ff   <= '0;
            body_remaining_ff <= '0;
            in_alpn_body_ff   <= 1'b0;
            error_seen_ff     <= 1'b0;
         end else begin
            list_len_ff       <= list_len_in;
            header_shift_ff   <= header_shift_in;
            header_count_ff   <= header_count_in;
            body_remaining_ff <= body_remaining_in;
            in_alpn_body_ff   <= in_alpn_body_in;
            error_seen_ff     <= error_seen_in;
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/tls_extension_list_walker.sv =====
// A request is held in the input register, then moved into the response register that drives rsp_valid.
// Throughput: one byte per cycle; input register, walker logic and response
// register form a two-stage pipeline that stalls only under rsp_stall.
// Reset (synchronous, active high) clears both stages, all parser state and
// sets the ALPN extension id register to 16.
// Top level: csr register, input stage, tlsx_walker and response stage.
`default_nettype none

module tls_extension_list_walker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_byte_out,
   output logic             rsp_alpn_data,
   output logic             rsp_alpn_first,
   output logic             rsp_done_res,
   output logic [1:0]       rsp_status,
   output logic             rsp_handshake_advance
);

   logic [15:0] alpn_ext_id_ff;
   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;
   logic        out_valid_ff;
   tlsx_pkg::result_type out_ff;
   tlsx_pkg::result_type result;
   logic        out_open;
   logic        step;
   logic        in_open;

   assign out_open  = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_open;
   assign in_open   = !in_valid_ff || step;
   assign req_stall = !in_open;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpn_ext_id_ff <= tlsx_pkg::ALPN_ID_RESET;
      end else if (csr_wr_en) begin
         alpn_ext_id_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_open) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_open && req_valid) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   tlsx_walker u_walker (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .data_byte   (in_byte_ff),
      .last_byte   (in_last_ff),
      .alpn_ext_id (alpn_ext_id_ff),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_open) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_ff <= result;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_byte_out          = out_ff.byte_out;
   assign rsp_alpn_data         = out_ff.alpn_data;
   assign rsp_alpn_first        = out_ff.alpn_first;
   assign rsp_done_res          = out_ff.done_res;
   assign rsp_status            = out_ff.status;
   assign rsp_handshake_advance = out_ff.handshake_advance;

endmodule

`default_nettype wire
